### rtl/core/gbc_pkg.sv
package gbc_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int PIXEL_BITS   = 8;

  // Configuration register width and derived counter widths
  localparam int CFG_BITS = 11;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  // Row counter runs up to height + 1 while the last row drains
  localparam int ROW_BITS = $clog2(HEIGHT_LIMIT + 2);

  // Kernel sum: total weight 16 adds four bits
  localparam int SUM_BITS = PIXEL_BITS + 4;

  // Input item kinds carried on cmd
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  // 3x3 window, row-major: tap (r, k) sits at index r*3 + k
  typedef pixel_t [8:0] win_t;

  // Edge repetition flags of the output pixel's neighborhood
  typedef struct packed {
    logic top;   // top row replaced by the center row
    logic bot;   // bottom row replaced by the center row
    logic lc;    // left column replaced by the center column
    logic rc;    // right column replaced by the center column
  } edge_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

### rtl/core/gbc_line_store.sv
module gbc_line_store (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  gbc_pkg::col_t   rd_addr,
  input  logic            wr_en,
  input  gbc_pkg::col_t   wr_addr,
  input  gbc_pkg::pixel_t wr_upper,
  input  gbc_pkg::pixel_t wr_middle,
  output gbc_pkg::pixel_t rd_upper,
  output gbc_pkg::pixel_t rd_middle
);
  import gbc_pkg::*;

  // Both line stores share one address: entry holds {upper, middle}
  logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_q;
  logic [2*PIXEL_BITS-1:0] fwd_q;
  logic                    fwd_hit;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_upper, wr_middle};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Hold the last write for a read that raced it to the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_q <= {wr_upper, wr_middle};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  // Select forwarded data over the stale read
  assign {rd_upper, rd_middle} = fwd_hit ? fwd_q : rd_q;

endmodule

### rtl/core/gbc_kernel.sv
module gbc_kernel (
  input  gbc_pkg::win_t   taps,
  input  gbc_pkg::edge_t  edges,
  output gbc_pkg::pixel_t result
);
  import gbc_pkg::*;

  localparam int ROW_SUM_BITS = PIXEL_BITS + 2;

  logic [ROW_SUM_BITS-1:0] row_sum [3];
  logic [SUM_BITS-1:0]     top_sum;
  logic [SUM_BITS-1:0]     bot_sum;
  logic [SUM_BITS-1:0]     total;

  // Weight each row 1-2-1 with edge columns folded onto the center
  always_comb begin
    pixel_t lft;
    pixel_t rgt;
    for (int r = 0; r < 3; r++) begin
      lft = edges.lc ? taps[r*3+1] : taps[r*3];
      rgt = edges.rc ? taps[r*3+1] : taps[r*3+2];
      row_sum[r] = ROW_SUM_BITS'(lft) + (ROW_SUM_BITS'(taps[r*3+1]) << 1)
                 + ROW_SUM_BITS'(rgt);
    end
  end

  // Weight rows 1-2-1 with edge rows folded onto the center
  assign top_sum = SUM_BITS'(edges.top ? row_sum[1] : row_sum[0]);
  assign bot_sum = SUM_BITS'(edges.bot ? row_sum[1] : row_sum[2]);
  assign total   = top_sum + (SUM_BITS'(row_sum[1]) << 1) + bot_sum;

  // Divide by 16, truncating
  assign result = total[SUM_BITS-1:4];

endmodule

### rtl/core/gaussian_blur_3x3_clamped.sv
// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, sum >> 4) over a raster pixel
// stream, with frame borders repeating the nearest edge pixel.
// Input channel (in_valid / in_stall): cmd = 0 carries a pixel in pixel_in,
// cmd = 1 is a drain item. Drains sent while pixels are still expected are
// taken and dropped; after the last pixel, width + 1 drains flush the final
// row and restart the frame. Pixels sent then count as drains.
// Output channel (out_valid / out_stall): pixel_out and frame_last, which
// marks the last pixel of the frame. Output trails input by one row and one
// pixel: the item that completes a neighborhood presents its result on the
// output after passing through stage 1 and the output register.
// Throughput is one item per cycle unless the output stalls: both line stores
// share one memory, read on transfer and written back as the item leaves
// stage 1, with a forwarding register for back-to-back same-entry accesses.
// A stalled output register holds its result; the input keeps flowing until
// the stage behind the output register also holds a result.
// Reset: width 640, height 480, input position at the frame start; memory
// contents are left as they are. Writing either size register restarts the
// frame. Sizes saturate to 1..1024.
module gaussian_blur_3x3_clamped (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  gbc_pkg::pixel_t   pixel_in,
  output logic              out_valid,
  input  logic              out_stall,
  output gbc_pkg::pixel_t   pixel_out,
  output logic              frame_last,
  input  logic              cfg_wr_en,
  input  gbc_pkg::cfg_reg_t cfg_index,
  input  logic [gbc_pkg::CFG_BITS-1:0] cfg_data
);
  import gbc_pkg::*;

  typedef struct packed {
    col_t   addr;
    pixel_t pixel;
    logic   first;
    logic   emit;
    edge_t  edges;
    logic   last;
  } s1_t;

  logic [W_BITS-1:0]   w_used;
  logic [W_BITS-1:0]   w_sat;
  logic [ROW_BITS-1:0] h_used;
  logic [ROW_BITS-1:0] h_sat;
  logic [ROW_BITS-1:0] h_plus;
  col_t                in_column;
  row_t                in_row;
  col_t                col_cur;
  logic [W_BITS-1:0]   col_inc;
  logic                pending;
  logic                accept;
  logic                take;
  s1_t                 s1;
  s1_t                 s1_next;
  logic                s1_valid;
  logic                s1_go;
  logic                out_free;
  pixel_t              up_rd;
  pixel_t              mid_rd;
  win_t                win;
  win_t                win_next;
  win_t                emit_taps;
  pixel_t              blur;

  // Saturate configured sizes to the supported range
  always_comb begin
    w_sat = W_BITS'(cfg_data);
    if (cfg_data == '0) begin
      w_sat = W_BITS'(1);
    end else if (cfg_data > CFG_BITS'(MAX_WIDTH)) begin
      w_sat = W_BITS'(MAX_WIDTH);
    end
    h_sat = ROW_BITS'(cfg_data);
    if (cfg_data == '0) begin
      h_sat = ROW_BITS'(1);
    end else if (cfg_data > CFG_BITS'(HEIGHT_LIMIT)) begin
      h_sat = ROW_BITS'(HEIGHT_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_used <= W_BITS'(640);
      h_used <= ROW_BITS'(480);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_used <= w_sat;
        REG_IMAGE_HEIGHT: h_used <= h_sat;
        default:          ;
      endcase
    end
  end

  // Handshake: stage 1 leaves when its result has somewhere to go
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1.emit || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  // Input position and drop of early drains
  assign col_cur = (W_BITS'(in_column) >= w_used) ? '0 : in_column;
  assign col_inc = W_BITS'(col_cur) + W_BITS'(1);
  assign pending = in_row < h_used;
  assign take    = accept && !((cmd == CMD_DRAIN) && pending);
  assign h_plus  = h_used + ROW_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (cfg_wr_en) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (take) begin
      if (in_row > h_used) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (col_inc >= w_used) begin
        in_column <= '0;
        in_row    <= in_row + ROW_BITS'(1);
      end else begin
        in_column <= col_inc[COL_BITS-1:0];
      end
    end
  end

  // Work out the output position's flags ahead of stage 1
  always_comb begin
    s1_next.addr  = col_cur;
    s1_next.pixel = pending ? pixel_in : '0;
    s1_next.first = (col_cur == '0);
    if (col_cur == '0) begin
      // Column zero finishes the last pixel of the row two above
      s1_next.emit      = in_row >= ROW_BITS'(2);
      s1_next.edges.top = in_row == ROW_BITS'(2);
      s1_next.edges.bot = in_row > h_used;
      s1_next.edges.lc  = w_used == W_BITS'(1);
      s1_next.edges.rc  = 1'b1;
      s1_next.last      = in_row == h_plus;
    end else begin
      s1_next.emit      = in_row >= ROW_BITS'(1);
      s1_next.edges.top = in_row == ROW_BITS'(1);
      s1_next.edges.bot = in_row >= h_used;
      s1_next.edges.lc  = col_cur == COL_BITS'(1);
      s1_next.edges.rc  = 1'b0;
      s1_next.last      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= s1_next;
    end
  end

  // Line stores: read on transfer, shift the column up on write-back
  gbc_line_store u_lines (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (take),
    .rd_addr   (col_cur),
    .wr_en     (s1_go),
    .wr_addr   (s1.addr),
    .wr_upper  (mid_rd),
    .wr_middle (s1.pixel),
    .rd_upper  (up_rd),
    .rd_middle (mid_rd)
  );

  // Window: a new column enters; at column zero the old right edge repeats
  always_comb begin
    pixel_t fresh;
    for (int r = 0; r < 3; r++) begin
      fresh = (r == 0) ? up_rd : ((r == 1) ? mid_rd : s1.pixel);
      emit_taps[r*3]   = win[r*3+1];
      emit_taps[r*3+1] = win[r*3+2];
      emit_taps[r*3+2] = s1.first ? win[r*3+2] : fresh;
      win_next[r*3]    = s1.first ? win[r*3+2] : win[r*3+1];
      win_next[r*3+1]  = win[r*3+2];
      win_next[r*3+2]  = fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_go) begin
      win <= win_next;
    end
  end

  gbc_kernel u_kernel (
    .taps   (emit_taps),
    .edges  (s1.edges),
    .result (blur)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.emit) begin
      pixel_out  <= blur;
      frame_last <= s1.last;
    end
  end

`ifndef SYNTHESIS
  // Stage 1 holds only behind a full, stalled output register
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> (out_valid && out_stall))
    else $error("stage 1 held without output back-pressure");

  // Input column stays inside the configured row
  assert property (@(posedge clk) disable iff (rst)
    W_BITS'(in_column) < w_used)
    else $error("input column beyond image width");

  // Row counter never runs past the drain row
  assert property (@(posedge clk) disable iff (rst)
    in_row <= h_plus)
    else $error("input row beyond drain row");

  // An early drain leaves the input position untouched
  assert property (@(posedge clk) disable iff (rst)
    (accept && !take && !cfg_wr_en) |=> ($stable(in_column) && $stable(in_row)))
    else $error("dropped drain moved the input position");
`endif

endmodule
